### sv/tcw_pkg.sv
// tcw_pkg: shared widths, command and character codes, fsm state and the
// controller/datapath command and status words of the text console writer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_MAX_ROWS = 25;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int WIN_W      = 5;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SETC  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd9;
    localparam logic [WIN_W-1:0]  RESET_WIN  = 5'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS = 1'd1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fill_step;
        logic fill_rst;
        logic copy_step;
        logic scroll_fix;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_setc;
        logic need_scroll;
        logic fill_last;
        logic copy_done;
        logic blank_last;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (status.is_setc)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.is_put && status.need_scroll)
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (status.blank_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CLEAR:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_rst  = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_CHECK:
            begin
                cmd = '0;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
            end
            ST_BLANK:
            begin
                cmd.fill_step  = 1'b1;
                cmd.scroll_fix = status.blank_last;
            end
            ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/tcw_dp.sv
// tcw_dp: screen memory, cursor registers, sweep counter and result words
// depends on tcw_pkg; driven by tcw_ctrl
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [CHAR_W-1:0]     char_code,
    input  wire logic [IDX_W-1:0]      cell_index,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       done,
    output logic [IDX_W-1:0]           cursor_cell,
    output logic                       scrolled,
    output logic [CHAR_W-1:0]          read_char,
    output logic [ATTR_W-1:0]          read_attr
);

    localparam int CELLS   = COLUMNS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int POS_W   = $clog2(CELLS + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int WCMP_W  = (ROW_W > WIN_W) ? ROW_W : WIN_W;
    localparam int TW      = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int QSH     = POS_W + $clog2(COLUMNS);
    localparam int QM_W    = POS_W + 2;
    localparam int PROD_W  = POS_W + QM_W;
    localparam logic [QM_W-1:0] QMUL =
        QM_W'(((longint'(1) << QSH) + longint'(COLUMNS) - 1) / longint'(COLUMNS));

    logic [CELL_W-1:0] cell_mem [CELLS];

    logic [FUNC_W-1:0] func_reg;
    logic [FUNC_W-1:0] func_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  base_reg;
    logic [POS_W-1:0]  base_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [POS_W-1:0]  swp_reg;
    logic [POS_W-1:0]  swp_next;
    logic              div_phase_reg;
    logic              div_phase_next;

    logic              cp_valid_reg;
    logic              cp_valid_next;
    logic [ADDR_W-1:0] cp_addr_reg;
    logic [ADDR_W-1:0] cp_addr_next;
    logic              hit_reg;
    logic              hit_next;
    logic              scr_reg;
    logic              scr_next;
    logic [CELL_W-1:0] rdata_reg;

    logic              done_reg;
    logic              done_next;
    logic [IDX_W-1:0]  cur_out_reg;
    logic [IDX_W-1:0]  cur_out_next;
    logic              scr_out_reg;
    logic              scr_out_next;
    logic [CHAR_W-1:0] rchar_reg;
    logic [CHAR_W-1:0] rchar_next;
    logic [ATTR_W-1:0] rattr_reg;
    logic [ATTR_W-1:0] rattr_next;

    logic [WCMP_W-1:0] win_ext;
    logic [ROW_W-1:0]  live_rows;
    logic [ROW_W-1:0]  last_row;
    logic [POS_W-1:0]  last_base;
    logic [POS_W-1:0]  wend;
    logic [TW-1:0]     idx_ext;
    logic [POS_W-1:0]  target;
    logic              copy_more;
    logic [CELL_W-1:0] blank_word;
    logic [PROD_W-1:0] quot_prod;
    logic [ROW_W-1:0]  quot_row;
    logic [POS_W-1:0]  row_base;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    // window geometry
    always_comb
    begin
        win_ext = WCMP_W'(win_reg);
        if (win_reg == '0)
        begin
            live_rows = ROW_W'(1);
        end
        else if (win_ext > WCMP_W'(MAX_ROWS))
        begin
            live_rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            live_rows = ROW_W'(win_ext);
        end
    end

    assign last_row  = live_rows - ROW_W'(1);
    assign last_base = POS_W'(last_row * COLUMNS);
    assign wend      = last_base + POS_W'(COLUMNS);
    assign idx_ext   = TW'(idx_reg);
    assign target    = (idx_ext >= TW'(wend)) ? (wend - POS_W'(1)) : POS_W'(idx_ext);
    assign copy_more = swp_reg < last_base;
    assign blank_word = cmd.fill_rst ? {RESET_ATTR, BLANK_CHAR} : {attr_reg, BLANK_CHAR};

    // row of the set cursor target by reciprocal multiplication
    assign quot_prod = PROD_W'(swp_reg) * PROD_W'(QMUL);
    assign quot_row  = ROW_W'(quot_prod >> QSH);
    assign row_base  = POS_W'(row_reg * COLUMNS);

    always_comb
    begin
        status.is_put      = (func_reg == FUNC_PUT);
        status.is_clear    = (func_reg == FUNC_CLEAR);
        status.is_setc     = (func_reg == FUNC_SETC);
        status.need_scroll = (row_reg >= live_rows);
        status.fill_last   = (swp_reg == POS_W'(CELLS - 1));
        status.copy_done   = !copy_more;
        status.blank_last  = (swp_reg == (wend - POS_W'(1)));
        status.div_done    = div_phase_reg;
    end

    // memory port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = swp_reg[ADDR_W-1:0];
        wdata = blank_word;
        re    = 1'b0;
        raddr = ADDR_W'(idx_reg);
        if (cp_valid_reg)
        begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rdata_reg;
        end
        else if (cmd.fill_step)
        begin
            we = 1'b1;
        end
        else if (cmd.exec && (func_reg == FUNC_PUT))
        begin
            case (char_reg)
                CH_NEWLINE, CH_RETURN:
                begin
                    we = 1'b0;
                end
                CH_BACKSPACE:
                begin
                    we    = (pos_reg != '0);
                    waddr = ADDR_W'(pos_reg - POS_W'(1));
                    wdata = {attr_reg, BLANK_CHAR};
                end
                default:
                begin
                    we    = 1'b1;
                    waddr = pos_reg[ADDR_W-1:0];
                    wdata = {attr_reg, char_reg};
                end
            endcase
        end

        if (cmd.exec && (func_reg == FUNC_READ))
        begin
            re    = (idx_ext < TW'(CELLS));
            raddr = ADDR_W'(idx_reg);
        end
        else if (cmd.copy_step && copy_more)
        begin
            re    = 1'b1;
            raddr = ADDR_W'(swp_reg + POS_W'(COLUMNS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= cell_mem[raddr];
        end
    end

    always_comb
    begin
        func_next      = func_reg;
        char_next      = char_reg;
        idx_next       = idx_reg;
        attr_next      = attr_reg;
        win_next       = win_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        swp_next       = swp_reg;
        hit_next       = hit_reg;
        scr_next       = scr_reg;
        div_phase_next = cmd.div_step && !div_phase_reg;
        cp_valid_next  = cmd.copy_step && copy_more;
        cp_addr_next   = swp_reg[ADDR_W-1:0];
        done_next      = cmd.finish;
        cur_out_next   = cur_out_reg;
        scr_out_next   = scr_out_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;

        if (cmd.load)
        begin
            func_next = func;
            char_next = char_code;
            idx_next  = cell_index;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEXT_ATTR:
                begin
                    attr_next = cfg_data;
                end
                CFG_WINDOW_ROWS:
                begin
                    win_next = cfg_data[WIN_W-1:0];
                end
                default:
                begin
                    attr_next = attr_reg;
                end
            endcase
        end

        if (cmd.exec)
        begin
            scr_next = 1'b0;
            swp_next = '0;
            hit_next = (idx_ext < TW'(CELLS));
            case (func_reg)
                FUNC_PUT:
                begin
                    case (char_reg)
                        CH_NEWLINE:
                        begin
                            row_next  = row_reg + ROW_W'(1);
                            base_next = base_reg + POS_W'(COLUMNS);
                            pos_next  = base_reg + POS_W'(COLUMNS);
                            col_next  = '0;
                        end
                        CH_RETURN:
                        begin
                            pos_next = base_reg;
                            col_next = '0;
                        end
                        CH_BACKSPACE:
                        begin
                            if (pos_reg != '0)
                            begin
                                pos_next = pos_reg - POS_W'(1);
                                if (col_reg == '0)
                                begin
                                    col_next  = COL_W'(COLUMNS - 1);
                                    row_next  = row_reg - ROW_W'(1);
                                    base_next = base_reg - POS_W'(COLUMNS);
                                end
                                else
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            pos_next = pos_reg + POS_W'(1);
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                col_next  = '0;
                                row_next  = row_reg + ROW_W'(1);
                                base_next = base_reg + POS_W'(COLUMNS);
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    endcase
                end
                FUNC_CLEAR:
                begin
                    pos_next  = '0;
                    base_next = '0;
                    row_next  = '0;
                    col_next  = '0;
                end
                FUNC_READ:
                begin
                    pos_next = pos_reg;
                end
                default:
                begin
                    // set cursor: split the saturated cell number into row and column
                    swp_next  = target;
                    base_next = '0;
                    row_next  = '0;
                end
            endcase
        end

        if (cmd.fill_step || (cmd.copy_step && copy_more))
        begin
            swp_next = swp_reg + POS_W'(1);
        end

        if (cmd.scroll_fix)
        begin
            row_next  = last_row;
            base_next = last_base;
            pos_next  = last_base + POS_W'(col_reg);
            scr_next  = 1'b1;
        end

        if (cmd.div_step)
        begin
            if (!div_phase_reg)
            begin
                row_next = quot_row;
            end
            else
            begin
                base_next = row_base;
                col_next  = COL_W'(swp_reg - row_base);
                pos_next  = swp_reg;
            end
        end

        if (cmd.finish)
        begin
            cur_out_next = IDX_W'(pos_reg);
            scr_out_next = scr_reg;
            if ((func_reg == FUNC_READ) && hit_reg)
            begin
                rchar_next = rdata_reg[CHAR_W-1:0];
                rattr_next = rdata_reg[CELL_W-1:CHAR_W];
            end
            else
            begin
                rchar_next = '0;
                rattr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= RESET_ATTR;
            win_reg       <= RESET_WIN;
            pos_reg       <= '0;
            base_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            swp_reg       <= '0;
            div_phase_reg <= 1'b0;
            cp_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            scr_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            attr_reg      <= attr_next;
            win_reg       <= win_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            swp_reg       <= swp_next;
            div_phase_reg <= div_phase_next;
            cp_valid_reg  <= cp_valid_next;
            hit_reg       <= hit_next;
            scr_reg       <= scr_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        char_reg    <= char_next;
        idx_reg     <= idx_next;
        cp_addr_reg <= cp_addr_next;
        cur_out_reg <= cur_out_next;
        scr_out_reg <= scr_out_next;
        rchar_reg   <= rchar_next;
        rattr_reg   <= rattr_next;
    end

    assign done        = done_reg;
    assign cursor_cell = cur_out_reg;
    assign scrolled    = scr_out_reg;
    assign read_char   = rchar_reg;
    assign read_attr   = rattr_reg;

endmodule

`default_nettype wire

### sv/text_console_writer.sv
// text_console_writer: top level, controller and datapath of the text console
// depends on tcw_pkg, tcw_ctrl, tcw_dp
//
// A command word (func, char_code, cell_index) is taken on a rising edge with
// start high and busy low. Exactly one result word follows on cursor_cell,
// scrolled, read_char and read_attr, marked by done for one cycle; the
// receiver takes it as it comes and cannot stall it. A read or a put without
// scroll passes the EXEC, CHECK and FIN states before done, and a set cursor
// passes EXEC, DIV and FIN; busy is already low in the done cycle, so the
// next word can be taken at the edge that ends it, and no word before that.
// The screen memory moves one cell per cycle in the longer cases: a put that
// scrolls copies the rows above the bottom one and then blanks the bottom row
// before done, and a clear blanks every cell before done. busy stays high
// throughout.
// After reset a clearing pass fills all COLUMNS*MAX_ROWS cells (2000 by default)
// with blanks of attribute 9 while busy is high.
// Registers text_attr (index 0) and window_rows (index 1) are written over
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. The user,
// not the block, sees that they are written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [CHAR_W-1:0]     char_code,
    input  wire logic [IDX_W-1:0]      cell_index,
    output logic                       done,
    output logic [IDX_W-1:0]           cursor_cell,
    output logic                       scrolled,
    output logic [CHAR_W-1:0]          read_char,
    output logic [ATTR_W-1:0]          read_attr,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tcw_dp #(
        .COLUMNS  (COLUMNS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .char_code   (char_code),
        .cell_index  (cell_index),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .cursor_cell (cursor_cell),
        .scrolled    (scrolled),
        .read_char   (read_char),
        .read_attr   (read_attr)
    );

    // an accepted word always keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // a result only appears once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // results of successive words are never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

### test/tb_text_console_writer.sv
// tb_text_console_writer: self-checking testbench for the text console writer,
// with its own screen and cursor predictor, a queue-fed driver and a monitor
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLS     = DEF_COLUMNS;
    localparam int ROWS_MAX = DEF_MAX_ROWS;
    localparam int CELLS    = COLS * ROWS_MAX;
    localparam int SETTLE   = 4;
    localparam int PHASES   = 14;

    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_CFG,
        STEP_SYNC
    } step_kind_t;

    typedef struct {
        step_kind_t            kind;
        logic [FUNC_W-1:0]     func;
        logic [CHAR_W-1:0]     char_code;
        logic [IDX_W-1:0]      cell_index;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } console_step_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_cell;
        logic              scrolled;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
    } console_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [FUNC_W-1:0]     func = FUNC_PUT;
    logic [CHAR_W-1:0]     char_code = '0;
    logic [IDX_W-1:0]      cell_index = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEXT_ATTR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  done;
    logic [IDX_W-1:0]      cursor_cell;
    logic                  scrolled;
    logic [CHAR_W-1:0]     read_char;
    logic [ATTR_W-1:0]     read_attr;
    logic                  cfg_ready;

    // predictor state
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                shadow_cursor;
    logic [ATTR_W-1:0] shadow_attr;
    logic [WIN_W-1:0]  shadow_rows;

    console_step_t pending_steps [$];
    console_word_t pending_results [$];

    logic word_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   gap_left = 0;
    int   quiet = 0;
    logic steady = 1'b0;
    int   mismatches = 0;
    int   words_sent = 0;
    int   reads_sent = 0;
    int   scrolls_seen = 0;
    int   cfg_writes = 0;
    int   window_plan [PHASES] = '{2, 1, 3, 25, 4, 0, 7, 31, 2, 5, 1, 3, 12, 26};

    text_console_writer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .char_code   (char_code),
        .cell_index  (cell_index),
        .done        (done),
        .cursor_cell (cursor_cell),
        .scrolled    (scrolled),
        .read_char   (read_char),
        .read_attr   (read_attr),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic int live_rows(int written);
        if (written == 0)
            return 1;
        if (written > ROWS_MAX)
            return ROWS_MAX;
        return written;
    endfunction

    function automatic console_word_t console_apply(logic [FUNC_W-1:0] f,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [IDX_W-1:0] idx);
        console_word_t r;
        int rows;
        int wend;
        int row;
        int base;
        r = '0;
        rows = live_rows(int'(shadow_rows));
        wend = rows * COLS;
        case (f)
            FUNC_PUT:
            begin
                row = shadow_cursor / COLS;
                if (ch == CH_NEWLINE)
                    shadow_cursor = (row + 1) * COLS;
                else if (ch == CH_RETURN)
                    shadow_cursor = row * COLS;
                else if (ch == CH_BACKSPACE)
                begin
                    if (shadow_cursor > 0)
                    begin
                        shadow_cursor--;
                        shadow_cells[shadow_cursor] = {shadow_attr, BLANK_CHAR};
                    end
                end
                else
                begin
                    shadow_cells[shadow_cursor] = {shadow_attr, ch};
                    shadow_cursor++;
                end
                if (shadow_cursor >= wend)
                begin
                    base = (rows - 1) * COLS;
                    for (int i = 0; i < base; i++)
                        shadow_cells[i] = shadow_cells[i + COLS];
                    for (int i = 0; i < COLS; i++)
                        shadow_cells[base + i] = {shadow_attr, BLANK_CHAR};
                    shadow_cursor = base + shadow_cursor % COLS;
                    r.scrolled = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = {shadow_attr, BLANK_CHAR};
                shadow_cursor = 0;
            end
            FUNC_READ:
            begin
                if (int'(idx) < CELLS)
                    {r.read_attr, r.read_char} = shadow_cells[idx];
            end
            default:
            begin
                shadow_cursor = (int'(idx) >= wend) ? wend - 1 : int'(idx);
            end
        endcase
        r.cursor_cell = IDX_W'(shadow_cursor);
        return r;
    endfunction

    task automatic queue_word(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
                              logic [IDX_W-1:0] idx);
        console_step_t s;
        s = '{STEP_WORD, f, ch, idx, CFG_TEXT_ATTR, '0};
        pending_steps.push_back(s);
    endtask

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        console_step_t s;
        s = '{STEP_CFG, FUNC_PUT, '0, '0, index, value};
        pending_steps.push_back(s);
    endtask

    task automatic queue_sync();
        console_step_t s;
        s = '{STEP_SYNC, FUNC_PUT, '0, '0, CFG_TEXT_ATTR, '0};
        pending_steps.push_back(s);
    endtask

    function automatic console_step_t random_word(int written_rows);
        console_step_t s;
        int pick;
        int sub;
        int span;
        span = live_rows(written_rows) * COLS;
        pick = $urandom_range(0, 999);
        s = '{STEP_WORD, FUNC_PUT, 8'($urandom), 11'($urandom), CFG_TEXT_ATTR, '0};
        if (pick < ((written_rows >= 10) ? 8 : 20))
            s.func = FUNC_CLEAR;
        else if (pick < 160)
        begin
            s.func = FUNC_READ;
            sub = $urandom_range(0, 9);
            if (sub < 6)
                s.cell_index = IDX_W'($urandom_range(0, span - 1));
            else if (sub < 9)
                s.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
        end
        else if (pick < 280)
        begin
            s.func = FUNC_SETC;
            if ($urandom_range(0, 1) == 0)
                s.cell_index = IDX_W'($urandom_range(0, span - 1));
        end
        else
        begin
            sub = $urandom_range(0, 99);
            if (sub < 12)
                s.char_code = CH_NEWLINE;
            else if (sub < 16)
                s.char_code = CH_RETURN;
            else if (sub < 24)
                s.char_code = CH_BACKSPACE;
        end
        return s;
    endfunction

    // driver
    always @(negedge clk)
    begin : driver
        logic next_start;
        logic next_cfg;
        next_start = start;
        next_cfg = cfg_valid;
        if (rst_n)
        begin
            if (start && word_taken)
            begin
                void'(pending_steps.pop_front());
                next_start = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    steady = ~steady;
                gap_left = steady ? 0 : $urandom_range(0, 7);
            end
            if (cfg_valid && cfg_taken)
            begin
                void'(pending_steps.pop_front());
                next_cfg = 1'b0;
                gap_left = $urandom_range(0, 7);
            end
            if (!next_start && !next_cfg && pending_steps.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    case (pending_steps[0].kind)
                        STEP_WORD:
                        begin
                            next_start = 1'b1;
                            func <= pending_steps[0].func;
                            char_code <= pending_steps[0].char_code;
                            cell_index <= pending_steps[0].cell_index;
                        end
                        STEP_CFG:
                        begin
                            if (pending_results.size() == 0 && !busy)
                            begin
                                if (quiet < SETTLE)
                                    quiet++;
                                else
                                begin
                                    quiet = 0;
                                    next_cfg = 1'b1;
                                    cfg_index <= pending_steps[0].reg_index;
                                    cfg_data <= pending_steps[0].reg_data;
                                end
                            end
                            else
                                quiet = 0;
                        end
                        default:
                        begin
                            if (pending_results.size() == 0)
                                void'(pending_steps.pop_front());
                        end
                    endcase
                end
            end
        end
        start <= next_start;
        cfg_valid <= next_cfg;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        console_word_t want;
        console_word_t fresh;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            word_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result word", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (cursor_cell !== want.cursor_cell)
                        report_mismatch("cursor_cell", int'(cursor_cell), int'(want.cursor_cell));
                    if (scrolled !== want.scrolled)
                        report_mismatch("scrolled", int'(scrolled), int'(want.scrolled));
                    if (read_char !== want.read_char)
                        report_mismatch("read_char", int'(read_char), int'(want.read_char));
                    if (read_attr !== want.read_attr)
                        report_mismatch("read_attr", int'(read_attr), int'(want.read_attr));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TEXT_ATTR)
                    shadow_attr = cfg_data;
                if (cfg_index == CFG_WINDOW_ROWS)
                    shadow_rows = cfg_data[WIN_W-1:0];
                cfg_writes++;
            end
            if (start && !busy)
            begin
                fresh = console_apply(func, char_code, cell_index);
                pending_results.push_back(fresh);
                words_sent++;
                if (func == FUNC_READ)
                    reads_sent++;
                if (fresh.scrolled)
                    scrolls_seen++;
            end
        end
    end

    initial
    begin
        int span;
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = {RESET_ATTR, BLANK_CHAR};
        shadow_cursor = 0;
        shadow_attr = RESET_ATTR;
        shadow_rows = RESET_WIN;

        // reset contents, field extremes and edge cases at the reset settings
        queue_word(FUNC_READ, '0, '0);
        queue_word(FUNC_READ, 8'hFF, 11'd1999);
        queue_word(FUNC_READ, '0, 11'd2047);
        queue_word(FUNC_PUT, 8'h41, '0);
        queue_word(FUNC_PUT, 8'hFF, '0);
        queue_word(FUNC_PUT, 8'h00, '0);
        queue_word(FUNC_PUT, CH_BACKSPACE, '0);
        queue_word(FUNC_PUT, CH_RETURN, '0);
        queue_word(FUNC_PUT, CH_BACKSPACE, '0);
        queue_word(FUNC_READ, '0, 11'd1);
        queue_word(FUNC_PUT, CH_NEWLINE, '0);
        queue_word(FUNC_SETC, '0, 11'd2047);
        queue_word(FUNC_PUT, 8'h5A, '0);
        queue_word(FUNC_READ, '0, 11'd1918);
        queue_word(FUNC_PUT, CH_NEWLINE, '0);
        queue_word(FUNC_SETC, '0, 11'd1500);
        queue_sync();
        // cursor left outside a shrunken window
        queue_cfg(CFG_WINDOW_ROWS, 8'd2);
        queue_word(FUNC_PUT, 8'h78, '0);
        queue_word(FUNC_READ, '0, 11'd1500);
        // zero rows acts as one
        queue_cfg(CFG_TEXT_ATTR, 8'hFF);
        queue_cfg(CFG_WINDOW_ROWS, 8'd0);
        queue_word(FUNC_SETC, '0, 11'd500);
        queue_word(FUNC_PUT, 8'h21, '0);
        queue_word(FUNC_PUT, CH_NEWLINE, '0);
        queue_word(FUNC_CLEAR, '0, '0);
        queue_word(FUNC_READ, '0, 11'd1999);
        queue_cfg(CFG_WINDOW_ROWS, 8'd31);
        queue_word(FUNC_SETC, '0, 11'd2047);

        for (int p = 0; p < PHASES; p++)
        begin
            queue_cfg(CFG_TEXT_ATTR, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
            queue_cfg(CFG_WINDOW_ROWS, {3'($urandom_range(0, 7)), 5'(window_plan[p])});
            span = (window_plan[p] >= 10) ? 80 : 140;
            for (int n = 0; n < span; n++)
            begin
                if (n == span / 2)
                    queue_sync();
                pending_steps.push_back(random_word(window_plan[p]));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_steps.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("ran %0d command words (%0d reads, %0d scrolls) and %0d register writes",
                 words_sent, reads_sent, scrolls_seen, cfg_writes);
        $display("window settings swept from zero rows to 31 with attributes 0 to 255");
        if (mismatches == 0)
            $display("text_console_writer verification clean");
        else
            $display("text_console_writer verification failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("timeout with %0d steps and %0d results outstanding",
                 pending_steps.size(), pending_results.size());
        $display("text_console_writer verification failed");
        $finish;
    end

endmodule
